// File: rtl/gss_pkg.sv
// gss_pkg: shared types and constants of the 3x3 gauss-seidel solver
// used by gss_ctrl, gss_dp and gauss_seidel_3x3_solver_core; no dependencies
`default_nettype none

package gss_pkg;

    localparam int EST_W     = 32;
    localparam int ITER_W    = 6;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_MUL_A,
        OP_MUL_B,
        OP_ACC,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_WRITE,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        ROW_X1,
        ROW_X2,
        ROW_X3
    } row_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_MUL_A,
        S_MUL_B,
        S_ACC,
        S_DIV_START,
        S_DIV_STEP,
        S_WRITE,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t                op;
        row_t               row;
        logic [ITER_W-1:0]  iter;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic pivot_bad;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/gss_in_if.sv
// gss_in_if: input channel carrying one 3x3 system per word
// no dependencies
`default_nettype none

interface gss_in_if #(
    parameter int COEF_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] a11;
    logic signed [COEF_BITS-1:0] a12;
    logic signed [COEF_BITS-1:0] a13;
    logic signed [COEF_BITS-1:0] rhs1;
    logic signed [COEF_BITS-1:0] a21;
    logic signed [COEF_BITS-1:0] a22;
    logic signed [COEF_BITS-1:0] a23;
    logic signed [COEF_BITS-1:0] rhs2;
    logic signed [COEF_BITS-1:0] a31;
    logic signed [COEF_BITS-1:0] a32;
    logic signed [COEF_BITS-1:0] a33;
    logic signed [COEF_BITS-1:0] rhs3;

    modport source (
        output valid, a11, a12, a13, rhs1, a21, a22, a23, rhs2, a31, a32, a33, rhs3,
        input  ready
    );

    modport sink (
        input  valid, a11, a12, a13, rhs1, a21, a22, a23, rhs2, a31, a32, a33, rhs3,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/gss_out_if.sv
// gss_out_if: result channel, one word per completed sweep
// no dependencies
`default_nettype none

interface gss_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         iteration;
    logic signed [31:0] est_x1;
    logic signed [31:0] est_x2;
    logic signed [31:0] est_x3;
    logic               saturated;
    logic               zero_pivot;
    logic               last;

    modport source (
        output valid, iteration, est_x1, est_x2, est_x3, saturated, zero_pivot, last,
        input  ready
    );

    modport sink (
        input  valid, iteration, est_x1, est_x2, est_x3, saturated, zero_pivot, last,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/gauss_seidel_3x3_solver_core.sv
// Gauss-Seidel solver for a 3x3 integer system. One input word starts a system; the
// block then emits ITERATIONS result words, one per sweep, with x1..x3 in signed Q16.16.
// Each of the three updates per sweep runs two multiplies, an accumulate, a 32-step
// restoring divide on one shared divider and a write-back; a sweep may then wait on
// the result register. With a zero diagonal a sweep skips the row updates and emits
// the zero estimates. A new system is accepted only after the last result word has
// been loaded into the output register.
// depends on gss_pkg, gss_in_if, gss_out_if, gss_ctrl, gss_dp
`default_nettype none

module gauss_seidel_3x3_solver_core #(
    parameter int ITERATIONS = 8,
    parameter int COEF_BITS  = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gss_in_if.sink     req,
    gss_out_if.source  rsp
);

    gss_pkg::cmd_t    cmd;
    gss_pkg::status_t status;

    gss_ctrl #(
        .ITERATIONS (ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gss_dp #(
        .COEF_BITS (COEF_BITS)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .a11        (req.a11),
        .a12        (req.a12),
        .a13        (req.a13),
        .rhs1       (req.rhs1),
        .a21        (req.a21),
        .a22        (req.a22),
        .a23        (req.a23),
        .rhs2       (req.rhs2),
        .a31        (req.a31),
        .a32        (req.a32),
        .a33        (req.a33),
        .rhs3       (req.rhs3),
        .status     (status),
        .iteration  (rsp.iteration),
        .est_x1     (rsp.est_x1),
        .est_x2     (rsp.est_x2),
        .est_x3     (rsp.est_x3),
        .saturated  (rsp.saturated),
        .zero_pivot (rsp.zero_pivot),
        .last       (rsp.last)
    );

endmodule

`default_nettype wire

// File: rtl/gss_dp.sv
// gss_dp: coefficient and estimate registers, multiplier, accumulator,
// radix-2 restoring divider and result register; depends on gss_pkg
`default_nettype none

module gss_dp #(
    parameter int COEF_BITS = 16
) (
    input  wire logic                           clk,
    input  wire gss_pkg::cmd_t                  cmd,
    input  wire logic signed [COEF_BITS-1:0]    a11,
    input  wire logic signed [COEF_BITS-1:0]    a12,
    input  wire logic signed [COEF_BITS-1:0]    a13,
    input  wire logic signed [COEF_BITS-1:0]    rhs1,
    input  wire logic signed [COEF_BITS-1:0]    a21,
    input  wire logic signed [COEF_BITS-1:0]    a22,
    input  wire logic signed [COEF_BITS-1:0]    a23,
    input  wire logic signed [COEF_BITS-1:0]    rhs2,
    input  wire logic signed [COEF_BITS-1:0]    a31,
    input  wire logic signed [COEF_BITS-1:0]    a32,
    input  wire logic signed [COEF_BITS-1:0]    a33,
    input  wire logic signed [COEF_BITS-1:0]    rhs3,
    output gss_pkg::status_t                    status,
    output logic [gss_pkg::ITER_W-1:0]          iteration,
    output logic signed [gss_pkg::EST_W-1:0]    est_x1,
    output logic signed [gss_pkg::EST_W-1:0]    est_x2,
    output logic signed [gss_pkg::EST_W-1:0]    est_x3,
    output logic                                saturated,
    output logic                                zero_pivot,
    output logic                                last
);

    localparam int CW = COEF_BITS;
    localparam int EW = gss_pkg::EST_W;
    localparam int PW = CW + EW;
    localparam int AW = CW + EW + 2;
    localparam int FW = gss_pkg::FRAC_W;

    logic signed [CW-1:0] c11_reg, c12_reg, c13_reg, b1_reg;
    logic signed [CW-1:0] c21_reg, c22_reg, c23_reg, b2_reg;
    logic signed [CW-1:0] c31_reg, c32_reg, c33_reg, b3_reg;
    logic signed [EW-1:0] x1_reg, x2_reg, x3_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic [CW-1:0]        rem_reg;
    logic [CW-1:0]        dmag_reg;
    logic [EW-1:0]        quo_reg;
    logic                 neg_reg;
    logic                 ovf_reg;
    logic                 sat_reg;
    logic                 pivot_reg;

    logic [gss_pkg::ITER_W-1:0] iter_out_reg;
    logic signed [EW-1:0]       x1_out_reg, x2_out_reg, x3_out_reg;
    logic                       sat_out_reg, pivot_out_reg, last_out_reg;

    logic signed [CW-1:0] rhs_sel, ca_sel, cb_sel, dg_sel;
    logic signed [EW-1:0] ea_sel, eb_sel;
    logic [AW-1:0]        nmag;
    logic [CW-1:0]        dmag;
    logic [CW:0]          trial;
    logic                 trial_ge;
    logic                 clip;
    logic signed [EW-1:0] quo_signed;

    always_comb
    begin
        case (cmd.row)
            gss_pkg::ROW_X2:
            begin
                rhs_sel = b2_reg;
                ca_sel  = c21_reg;
                ea_sel  = x1_reg;
                cb_sel  = c23_reg;
                eb_sel  = x3_reg;
                dg_sel  = c22_reg;
            end
            gss_pkg::ROW_X3:
            begin
                rhs_sel = b3_reg;
                ca_sel  = c31_reg;
                ea_sel  = x1_reg;
                cb_sel  = c32_reg;
                eb_sel  = x2_reg;
                dg_sel  = c33_reg;
            end
            default:
            begin
                rhs_sel = b1_reg;
                ca_sel  = c12_reg;
                ea_sel  = x2_reg;
                cb_sel  = c13_reg;
                eb_sel  = x3_reg;
                dg_sel  = c11_reg;
            end
        endcase
    end

    always_comb
    begin
        nmag = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        dmag = dg_sel[CW-1] ? CW'(-dg_sel) : CW'(dg_sel);
        trial = {rem_reg, quo_reg[EW-1]};
        trial_ge = (trial >= {1'b0, dmag_reg});
        if (ovf_reg)
        begin
            clip = 1'b1;
        end
        else if (neg_reg)
        begin
            clip = quo_reg[EW-1] && (quo_reg[EW-2:0] != '0);
        end
        else
        begin
            clip = quo_reg[EW-1];
        end
        if (clip)
        begin
            quo_signed = neg_reg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        end
        else
        begin
            quo_signed = neg_reg ? EW'(-quo_reg) : EW'(quo_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            gss_pkg::OP_LOAD:
            begin
                c11_reg   <= a11;
                c12_reg   <= a12;
                c13_reg   <= a13;
                b1_reg    <= rhs1;
                c21_reg   <= a21;
                c22_reg   <= a22;
                c23_reg   <= a23;
                b2_reg    <= rhs2;
                c31_reg   <= a31;
                c32_reg   <= a32;
                c33_reg   <= a33;
                b3_reg    <= rhs3;
                x1_reg    <= '0;
                x2_reg    <= '0;
                x3_reg    <= '0;
                pivot_reg <= (a11 == '0) || (a22 == '0) || (a33 == '0);
            end
            gss_pkg::OP_CLEAR:
            begin
                sat_reg <= 1'b0;
            end
            gss_pkg::OP_MUL_A:
            begin
                prod_reg <= ca_sel * ea_sel;
                acc_reg  <= {{(AW-CW-FW){rhs_sel[CW-1]}}, rhs_sel, {FW{1'b0}}};
            end
            gss_pkg::OP_MUL_B:
            begin
                acc_reg  <= acc_reg - AW'(prod_reg);
                prod_reg <= cb_sel * eb_sel;
            end
            gss_pkg::OP_ACC:
            begin
                acc_reg <= acc_reg - AW'(prod_reg);
            end
            gss_pkg::OP_DIV_START:
            begin
                ovf_reg  <= nmag >= AW'({dmag, {EW{1'b0}}});
                rem_reg  <= nmag[CW+EW-1:EW];
                quo_reg  <= nmag[EW-1:0];
                dmag_reg <= dmag;
                neg_reg  <= acc_reg[AW-1] ^ dg_sel[CW-1];
            end
            gss_pkg::OP_DIV_STEP:
            begin
                if (trial_ge)
                begin
                    rem_reg <= CW'(trial - {1'b0, dmag_reg});
                    quo_reg <= {quo_reg[EW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[CW-1:0];
                    quo_reg <= {quo_reg[EW-2:0], 1'b0};
                end
            end
            gss_pkg::OP_WRITE:
            begin
                sat_reg <= sat_reg | clip;
                case (cmd.row)
                    gss_pkg::ROW_X2: x2_reg <= quo_signed;
                    gss_pkg::ROW_X3: x3_reg <= quo_signed;
                    default:         x1_reg <= quo_signed;
                endcase
            end
            gss_pkg::OP_EMIT:
            begin
                iter_out_reg  <= cmd.iter;
                x1_out_reg    <= x1_reg;
                x2_out_reg    <= x2_reg;
                x3_out_reg    <= x3_reg;
                sat_out_reg   <= sat_reg;
                pivot_out_reg <= pivot_reg;
                last_out_reg  <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    assign status.pivot_bad = pivot_reg;
    assign iteration  = iter_out_reg;
    assign est_x1     = x1_out_reg;
    assign est_x2     = x2_out_reg;
    assign est_x3     = x3_out_reg;
    assign saturated  = sat_out_reg;
    assign zero_pivot = pivot_out_reg;
    assign last       = last_out_reg;

endmodule

`default_nettype wire

// File: rtl/gss_ctrl.sv
// gss_ctrl: sequencer for sweeps, row updates and divider steps
// depends on gss_pkg; drives gss_dp through a command word
`default_nettype none

module gss_ctrl #(
    parameter int ITERATIONS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire gss_pkg::status_t  status,
    output gss_pkg::cmd_t          cmd
);

    localparam logic [gss_pkg::ITER_W-1:0] ITER_LAST = gss_pkg::ITER_W'(ITERATIONS - 1);
    localparam logic [gss_pkg::DIV_CNT_W-1:0] DIV_LAST =
        gss_pkg::DIV_CNT_W'(gss_pkg::DIV_STEPS - 1);

    gss_pkg::state_t                state_reg, state_next;
    gss_pkg::row_t                  row_reg, row_next;
    logic [gss_pkg::ITER_W-1:0]     sweep_reg, sweep_next;
    logic [gss_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gss_pkg::S_IDLE;
            row_reg       <= gss_pkg::ROW_X1;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        sweep_next     = sweep_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = gss_pkg::OP_NONE;
        cmd.row        = row_reg;
        cmd.iter       = sweep_reg;
        cmd.last       = (sweep_reg == ITER_LAST);
        case (state_reg)
            gss_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = gss_pkg::OP_LOAD;
                    sweep_next = '0;
                    state_next = gss_pkg::S_SWEEP;
                end
            end
            gss_pkg::S_SWEEP:
            begin
                cmd.op   = gss_pkg::OP_CLEAR;
                row_next = gss_pkg::ROW_X1;
                state_next = status.pivot_bad ? gss_pkg::S_EMIT : gss_pkg::S_MUL_A;
            end
            gss_pkg::S_MUL_A:
            begin
                cmd.op     = gss_pkg::OP_MUL_A;
                state_next = gss_pkg::S_MUL_B;
            end
            gss_pkg::S_MUL_B:
            begin
                cmd.op     = gss_pkg::OP_MUL_B;
                state_next = gss_pkg::S_ACC;
            end
            gss_pkg::S_ACC:
            begin
                cmd.op     = gss_pkg::OP_ACC;
                state_next = gss_pkg::S_DIV_START;
            end
            gss_pkg::S_DIV_START:
            begin
                cmd.op     = gss_pkg::OP_DIV_START;
                cnt_next   = '0;
                state_next = gss_pkg::S_DIV_STEP;
            end
            gss_pkg::S_DIV_STEP:
            begin
                cmd.op   = gss_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = gss_pkg::S_WRITE;
                end
            end
            gss_pkg::S_WRITE:
            begin
                cmd.op = gss_pkg::OP_WRITE;
                if (row_reg == gss_pkg::ROW_X3)
                begin
                    state_next = gss_pkg::S_EMIT;
                end
                else
                begin
                    row_next   = gss_pkg::row_t'(row_reg + 1'b1);
                    state_next = gss_pkg::S_MUL_A;
                end
            end
            gss_pkg::S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = gss_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    if (sweep_reg == ITER_LAST)
                    begin
                        state_next = gss_pkg::S_IDLE;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + 1'b1;
                        state_next = gss_pkg::S_SWEEP;
                    end
                end
            end
            default:
            begin
                state_next = gss_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// testbench: checks gauss_seidel_3x3_solver_core against a sweep-by-sweep predictor
// depends on gss_pkg, gss_in_if, gss_out_if and the solver rtl
`timescale 1ns / 100ps

module testbench;

    localparam int ITERATIONS  = 8;
    localparam int COEF_BITS   = 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD   = 3000;
    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;

    typedef logic signed [COEF_BITS-1:0] coef_set_t [12];

    typedef struct packed {
        logic [gss_pkg::ITER_W-1:0]       iteration;
        logic signed [gss_pkg::EST_W-1:0] est_x1;
        logic signed [gss_pkg::EST_W-1:0] est_x2;
        logic signed [gss_pkg::EST_W-1:0] est_x3;
        logic                             saturated;
        logic                             zero_pivot;
        logic                             last;
    } sweep_word_t;

    logic clk;
    logic rst_n;

    gss_in_if #(.COEF_BITS(COEF_BITS)) req_if ();
    gss_out_if rsp_if ();

    gauss_seidel_3x3_solver_core #(
        .ITERATIONS(ITERATIONS),
        .COEF_BITS (COEF_BITS)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    sweep_word_t sweep_queue[$];
    int          error_count;
    int          cycle_count;
    int          stall_left;
    bit          hold_request;
    bit          rx_random;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // predicted sweeps of one system
    function automatic longint divide_clip(input longint num, input longint diag,
                                           inout bit clip);
        longint q;
        q = num / diag;
        if (q > EST_MAX)
        begin
            clip = 1'b1;
            return EST_MAX;
        end
        if (q < EST_MIN)
        begin
            clip = 1'b1;
            return EST_MIN;
        end
        return q;
    endfunction

    function automatic void predict_sweeps(input coef_set_t c);
        longint      k[12];
        longint      x1;
        longint      x2;
        longint      x3;
        bit          pivot_bad;
        bit          clip;
        sweep_word_t w;
        for (int i = 0; i < 12; i++)
            k[i] = longint'(c[i]);
        x1 = 0;
        x2 = 0;
        x3 = 0;
        pivot_bad = (k[0] == 0) || (k[5] == 0) || (k[10] == 0);
        for (int s = 0; s < ITERATIONS; s++)
        begin
            clip = 1'b0;
            if (!pivot_bad)
            begin
                x1 = divide_clip(k[3] * 65536 - k[1] * x2 - k[2] * x3, k[0], clip);
                x2 = divide_clip(k[7] * 65536 - k[4] * x1 - k[6] * x3, k[5], clip);
                x3 = divide_clip(k[11] * 65536 - k[8] * x1 - k[9] * x2, k[10], clip);
            end
            w.iteration  = s[gss_pkg::ITER_W-1:0];
            w.est_x1     = x1[gss_pkg::EST_W-1:0];
            w.est_x2     = x2[gss_pkg::EST_W-1:0];
            w.est_x3     = x3[gss_pkg::EST_W-1:0];
            w.saturated  = clip;
            w.zero_pivot = pivot_bad;
            w.last       = (s == ITERATIONS - 1);
            sweep_queue.push_back(w);
        end
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    task automatic send_system(input coef_set_t c, input bit gaps);
        int gap;
        req_if.a11  <= c[0];
        req_if.a12  <= c[1];
        req_if.a13  <= c[2];
        req_if.rhs1 <= c[3];
        req_if.a21  <= c[4];
        req_if.a22  <= c[5];
        req_if.a23  <= c[6];
        req_if.rhs2 <= c[7];
        req_if.a31  <= c[8];
        req_if.a32  <= c[9];
        req_if.a33  <= c[10];
        req_if.rhs3 <= c[11];
        req_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_sweeps(c);
        gap = gaps ? idle_gap() : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (sweep_queue.size() != 0)
            @(posedge clk);
    endtask

    function automatic coef_set_t dominant_system();
        coef_set_t c;
        int        m;
        int        d;
        m = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 4000);
        for (int i = 0; i < 12; i++)
            c[i] = COEF_BITS'($urandom_range(0, 2 * m) - m);
        for (int i = 0; i < 3; i++)
        begin
            d = 2 * m + 1 + $urandom_range(0, 3 * m + 50);
            if (d > 32767)
                d = 32767;
            c[i * 5] = COEF_BITS'($urandom_range(0, 1) ? d : -d);
            c[i * 4 + 3] = COEF_BITS'($urandom);
        end
        return c;
    endfunction

    function automatic coef_set_t raw_system();
        coef_set_t c;
        for (int i = 0; i < 12; i++)
            c[i] = COEF_BITS'($urandom);
        return c;
    endfunction

    function automatic coef_set_t fill_system(input int diag, input int off, input int rhs);
        coef_set_t c;
        for (int i = 0; i < 12; i++)
            c[i] = COEF_BITS'(off);
        c[0]  = COEF_BITS'(diag);
        c[5]  = COEF_BITS'(diag);
        c[10] = COEF_BITS'(diag);
        c[3]  = COEF_BITS'(rhs);
        c[7]  = COEF_BITS'(rhs);
        c[11] = COEF_BITS'(rhs);
        return c;
    endfunction

    task automatic test_directed();
        coef_set_t c;
        send_system(fill_system(1, 0, 1), 1'b1);
        send_system(fill_system(32767, 0, 32767), 1'b1);
        send_system(fill_system(-32768, 0, -32768), 1'b1);
        send_system(fill_system(1, 0, 32767), 1'b1);
        send_system(fill_system(1, 0, -32768), 1'b1);
        send_system(fill_system(-1, 0, -32768), 1'b1);
        send_system(fill_system(32767, 32767, 32767), 1'b1);
        send_system(fill_system(-32768, -32768, -32768), 1'b1);
        send_system(fill_system(1, -32768, 32767), 1'b1);
        send_system(fill_system(1, 32767, -32768), 1'b1);
        send_system(fill_system(10, 3, 7), 1'b1);
        send_system(fill_system(-7, 2, -5), 1'b1);
        send_system(fill_system(0, 5, 9), 1'b1);
        for (int i = 0; i < 3; i++)
        begin
            c = fill_system(4, 1, 100);
            c[i * 5] = '0;
            send_system(c, 1'b1);
        end
        c = fill_system(0, -32768, -32768);
        send_system(c, 1'b1);
        c = fill_system(3, 1, 0);
        c[3] = 16'sd30000;
        c[7] = -16'sd1;
        send_system(c, 1'b1);
        req_if.valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random_dominant(input int count);
        repeat (count) send_system(dominant_system(), 1'b1);
    endtask

    task automatic test_random_raw(input int count);
        repeat (count) send_system(raw_system(), 1'b1);
    endtask

    task automatic test_output_hold();
        hold_request = 1'b1;
        repeat (4) send_system(dominant_system(), 1'b0);
        req_if.valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (3) send_system(dominant_system(), 1'b1);
        req_if.valid <= 1'b0;
        wait_drained();
        repeat (3) send_system(raw_system(), 1'b0);
        req_if.valid <= 1'b0;
        wait_drained();
    endtask

    // result side: checks each accepted word; random stalls when rx_random is set, plus a long hold when asked
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
                check_word();
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (rx_random && $urandom_range(0, 7) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                              : $urandom_range(1, 4);
            end
        end
    end

    task automatic check_word();
        sweep_word_t w;
        sweep_word_t got;
        got.iteration  = rsp_if.iteration;
        got.est_x1     = rsp_if.est_x1;
        got.est_x2     = rsp_if.est_x2;
        got.est_x3     = rsp_if.est_x3;
        got.saturated  = rsp_if.saturated;
        got.zero_pivot = rsp_if.zero_pivot;
        got.last       = rsp_if.last;
        if (sweep_queue.size() == 0)
        begin
            $display("%0t: unexpected word %p", $time, got);
            error_count++;
            return;
        end
        w = sweep_queue.pop_front();
        if (got.iteration !== w.iteration)
        begin
            $display("%0t: iteration exp %0d got %0d", $time, w.iteration, got.iteration);
            error_count++;
        end
        if (got.est_x1 !== w.est_x1)
        begin
            $display("%0t: est_x1 exp %0d got %0d", $time, w.est_x1, got.est_x1);
            error_count++;
        end
        if (got.est_x2 !== w.est_x2)
        begin
            $display("%0t: est_x2 exp %0d got %0d", $time, w.est_x2, got.est_x2);
            error_count++;
        end
        if (got.est_x3 !== w.est_x3)
        begin
            $display("%0t: est_x3 exp %0d got %0d", $time, w.est_x3, got.est_x3);
            error_count++;
        end
        if (got.saturated !== w.saturated)
        begin
            $display("%0t: saturated exp %0b got %0b", $time, w.saturated, got.saturated);
            error_count++;
        end
        if (got.zero_pivot !== w.zero_pivot)
        begin
            $display("%0t: zero_pivot exp %0b got %0b", $time, w.zero_pivot,
                     got.zero_pivot);
            error_count++;
        end
        if (got.last !== w.last)
        begin
            $display("%0t: last exp %0b got %0b", $time, w.last, got.last);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        error_count  = 0;
        cycle_count  = 0;
        stall_left   = 0;
        hold_request = 1'b0;
        rx_random    = 1'b0;
        rst_n        = 1'b0;
        rsp_if.ready = 1'b0;
        req_if.valid = 1'b0;
        req_if.a11   = '0;
        req_if.a12   = '0;
        req_if.a13   = '0;
        req_if.rhs1  = '0;
        req_if.a21   = '0;
        req_if.a22   = '0;
        req_if.a23   = '0;
        req_if.rhs2  = '0;
        req_if.a31   = '0;
        req_if.a32   = '0;
        req_if.a33   = '0;
        req_if.rhs3  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        rx_random = 1'b1;
        test_random_dominant(120);
        test_output_hold();
        test_random_raw(60);
        test_sender_pause();
        test_random_dominant(90);
        rx_random = 1'b0;
        test_random_raw(20);
        req_if.valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
